FILE: rtl/mmcs_pkg.sv
// Package with the shared constants and types of the min-max contrast stretch block.
`default_nettype none
package mmcs_pkg;
    localparam int NUM_CH     = 4;    // channels carried by one pixel
    localparam int CHANNELS   = 4;    // channels that are stretched, 1 to 4
    localparam int PIX_W      = 8;
    localparam int DIV_STEPS  = PIX_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic meas;     // measure transaction accepted
        logic restart;  // statistics start over before the update
        logic load;     // apply transaction accepted
        logic step;     // one divider iteration
    } t_lane_ctrl;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_pixel;
endpackage
`default_nettype wire

FILE: rtl/min_max_contrast_stretch_unit.sv
// Top level of the per-channel min-max contrast stretch of RGBA pixels.
//
// Input channel: i_valid / o_stall carry one pixel with i_func and i_in_last.
// A measure transaction (i_func = 0) updates each channel's min and max in the
// cycle it is accepted and gives no result; the block is ready again at once.
// The first measure transaction after a finished pass restarts the statistics,
// and one with i_in_last set closes the pass and freezes them.
// An apply transaction (i_func = 1) gives one output pixel. Each stretched
// channel has its own lane with a one-bit-per-cycle restoring divider, so an
// apply transaction keeps o_stall high through the 8 divider iterations
// (S_DIV) and the handoff (S_DONE), so no new pixel is taken until it is
// through. Measure pixels are taken one per cycle while no apply transaction
// holds the lanes.
// Output channel: o_valid / i_stall. The result sits in an output register, so
// the block accepts further measure transactions while it waits; an apply
// result that finds the register full with i_stall high waits in the lanes
// (o_stall high). Synchronous active-low reset sets min to 255, max to 0,
// closes the pass and empties the output register.
`default_nettype none
module min_max_contrast_stretch_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire logic i_func,
    input  wire logic [7:0] i_in_red,
    input  wire logic [7:0] i_in_green,
    input  wire logic [7:0] i_in_blue,
    input  wire logic [7:0] i_in_alpha,
    input  wire logic i_in_last,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [7:0] o_out_alpha,
    output logic      o_out_last
);
    mmcs_pkg::t_state       r_state, n_state;
    logic [mmcs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                   r_measuring, n_measuring;
    logic                   r_last;
    mmcs_pkg::t_pixel       r_px, in_px, lane_res, out_px;
    mmcs_pkg::t_lane_ctrl   ctrl;
    logic                   accept, push, taken;

    assign in_px  = {i_in_alpha, i_in_blue, i_in_green, i_in_red};
    assign accept = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mmcs_pkg::S_IDLE: begin
                if (accept && i_func == mmcs_pkg::FUNC_APPLY) begin
                    n_state = mmcs_pkg::S_DIV;
                end
            end
            mmcs_pkg::S_DIV: begin
                if (r_cnt == mmcs_pkg::CNT_W'(mmcs_pkg::DIV_STEPS - 1)) begin
                    n_state = mmcs_pkg::S_DONE;
                end
            end
            mmcs_pkg::S_DONE: begin
                if (taken) begin
                    n_state = mmcs_pkg::S_IDLE;
                end
            end
            default: n_state = mmcs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall      = 1'b1;
        push         = 1'b0;
        ctrl.meas    = 1'b0;
        ctrl.restart = 1'b0;
        ctrl.load    = 1'b0;
        ctrl.step    = 1'b0;
        n_cnt        = r_cnt;
        n_measuring  = r_measuring;
        case (r_state)
            mmcs_pkg::S_IDLE: begin
                o_stall = 1'b0;
                n_cnt   = '0;
                if (accept) begin
                    if (i_func == mmcs_pkg::FUNC_MEASURE) begin
                        ctrl.meas    = 1'b1;
                        ctrl.restart = !r_measuring;
                        n_measuring  = !i_in_last;
                    end else begin
                        ctrl.load = 1'b1;
                    end
                end
            end
            mmcs_pkg::S_DIV: begin
                ctrl.step = 1'b1;
                n_cnt     = r_cnt + 1'b1;
            end
            mmcs_pkg::S_DONE: begin
                push = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmcs_pkg::S_IDLE;
            r_cnt       <= '0;
            r_measuring <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_measuring <= n_measuring;
        end
        if (ctrl.load) begin
            r_px   <= in_px;
            r_last <= i_in_last;
        end
    end

    // Channels past CHANNELS keep no statistics and pass through.
    for (genvar c = 0; c < mmcs_pkg::NUM_CH; c++) begin : g_lane
        if (c < mmcs_pkg::CHANNELS) begin : g_stretch
            mmcs_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctrl   (ctrl),
                .i_x      (in_px[c]),
                .o_result (lane_res[c])
            );
        end else begin : g_pass
            assign lane_res[c] = r_px[c];
        end
    end

    mmcs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (lane_res),
        .i_last  (r_last),
        .i_stall (i_stall),
        .o_taken (taken),
        .o_valid (o_valid),
        .o_data  (out_px),
        .o_last  (o_out_last)
    );

    assign o_out_red   = out_px[0];
    assign o_out_green = out_px[1];
    assign o_out_blue  = out_px[2];
    assign o_out_alpha = out_px[3];
endmodule
`default_nettype wire

FILE: rtl/mmcs_lane.sv
// One channel lane: running min and max plus a bit-serial stretch divider.
`default_nettype none
module mmcs_lane (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mmcs_pkg::t_lane_ctrl       i_ctrl,
    input  wire logic [mmcs_pkg::PIX_W-1:0] i_x,
    output logic      [mmcs_pkg::PIX_W-1:0] o_result
);
    logic [mmcs_pkg::PIX_W-1:0] r_min, n_min, r_max, n_max;
    logic [mmcs_pkg::PIX_W-1:0] base_min, base_max;
    logic [mmcs_pkg::PIX_W-1:0] r_rem, n_rem, r_numlo, n_numlo;
    logic [mmcs_pkg::PIX_W-1:0] r_div, n_div, r_q, n_q;
    logic [mmcs_pkg::PIX_W-1:0] r_spec_val, n_spec_val;
    logic                       r_spec, n_spec;
    logic [mmcs_pkg::PIX_W-1:0] diff;
    logic [2*mmcs_pkg::PIX_W-1:0] num;
    logic [mmcs_pkg::PIX_W:0]   trial;
    logic                       fits;

    always_comb begin
        base_min = i_ctrl.restart ? mmcs_pkg::FULL_SCALE : r_min;
        base_max = i_ctrl.restart ? '0 : r_max;
        n_min = r_min;
        n_max = r_max;
        if (i_ctrl.meas) begin
            n_min = (i_x < base_min) ? i_x : base_min;
            n_max = (i_x > base_max) ? i_x : base_max;
        end
    end

    // 255 * (x - min) as a shift and a subtract.
    always_comb begin
        diff = i_x - r_min;
        num  = {diff, {mmcs_pkg::PIX_W{1'b0}}} - {{mmcs_pkg::PIX_W{1'b0}}, diff};
        trial = {r_rem, r_numlo[mmcs_pkg::PIX_W-1]};
        fits  = (trial >= {1'b0, r_div});
    end

    always_comb begin
        n_rem      = r_rem;
        n_numlo    = r_numlo;
        n_div      = r_div;
        n_q        = r_q;
        n_spec     = r_spec;
        n_spec_val = r_spec_val;
        if (i_ctrl.load) begin
            n_rem   = num[2*mmcs_pkg::PIX_W-1:mmcs_pkg::PIX_W];
            n_numlo = num[mmcs_pkg::PIX_W-1:0];
            n_div   = r_max - r_min;
            n_q     = '0;
            n_spec  = 1'b1;
            if (r_max <= r_min) begin
                n_spec_val = i_x;
            end else if (i_x <= r_min) begin
                n_spec_val = '0;
            end else if (i_x >= r_max) begin
                n_spec_val = mmcs_pkg::FULL_SCALE;
            end else begin
                n_spec     = 1'b0;
                n_spec_val = '0;
            end
        end else if (i_ctrl.step) begin
            // The partial remainder stays below the divisor, so it fits in PIX_W bits.
            n_rem   = fits ? trial[mmcs_pkg::PIX_W-1:0] - r_div
                           : trial[mmcs_pkg::PIX_W-1:0];
            n_numlo = {r_numlo[mmcs_pkg::PIX_W-2:0], 1'b0};
            n_q     = {r_q[mmcs_pkg::PIX_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= mmcs_pkg::FULL_SCALE;
            r_max <= '0;
        end else begin
            r_min <= n_min;
            r_max <= n_max;
        end
        r_rem      <= n_rem;
        r_numlo    <= n_numlo;
        r_div      <= n_div;
        r_q        <= n_q;
        r_spec     <= n_spec;
        r_spec_val <= n_spec_val;
    end

    assign o_result = r_spec ? r_spec_val : r_q;
endmodule
`default_nettype wire

FILE: rtl/mmcs_merge.sv
// Merging stage: gathers the lane results into the registered output transaction.
`default_nettype none
module mmcs_merge (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mmcs_pkg::t_pixel i_data,
    input  wire logic             i_last,
    input  wire logic             i_stall,
    output logic                  o_taken,
    output logic                  o_valid,
    output mmcs_pkg::t_pixel      o_data,
    output logic                  o_last
);
    logic             r_valid, n_valid;
    mmcs_pkg::t_pixel r_data;
    logic             r_last;

    assign o_taken = i_push && (!r_valid || !i_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_taken) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_taken) begin
            r_data <= i_data;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
endmodule
`default_nettype wire

FILE: rtl/mmcs_checker.sv
// Port-level checker for the contrast stretch unit, bound to the top level.
`default_nettype none
module mmcs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       i_func,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_red,
    input wire logic       o_out_last
);
    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red) && $stable(o_out_last))
        else $error("stalled result changed");

    // An apply transaction occupies the divider lanes.
    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_func |=> o_stall)
        else $error("block not busy after an apply transaction");

    // A measure transaction finishes in the cycle it is accepted.
    a_measure_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_func |=> !o_stall)
        else $error("block busy after a measure transaction");

    // A new result only follows a busy cycle of the lanes.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without apply work");
endmodule

bind min_max_contrast_stretch_unit mmcs_checker u_mmcs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .i_func     (i_func),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_red  (o_out_red),
    .o_out_last (o_out_last)
);
`default_nettype wire
